### sv/tdq_pkg.sv
package tdq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int DL_W        = 32;
	localparam int CB_W        = 8;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CHECK = 1'b1
	} op_code_t;

	typedef struct packed {
		logic            valid;
		logic [DL_W-1:0] deadline;
		logic [CB_W-1:0] callback;
	} entry_t;

endpackage

### sv/tdq_cell.sv
module tdq_cell
	import tdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  entry_t   new_ent,
	input  entry_t   left_ent,
	input  logic     left_keep,
	input  entry_t   right_ent,
	output entry_t   ent,
	output logic     keep
);

	logic            valid_q;
	logic [DL_W-1:0] deadline_q;
	logic [CB_W-1:0] callback_q;
	entry_t          nxt;
	logic            load;

	// keep: this entry stays put on insert (ties stay ahead of the new word)
	assign keep = valid_q && (deadline_q <= new_ent.deadline);
	assign ent  = '{valid: valid_q, deadline: deadline_q, callback: callback_q};

	always_comb begin
		nxt  = ent;
		load = 1'b0;
		unique case (op)
			CELL_HOLD: begin
				load = 1'b0;
			end
			CELL_INSERT: begin
				if (!keep) begin
					load = 1'b1;
					nxt  = left_keep ? new_ent : left_ent;
				end
			end
			CELL_POP: begin
				load = 1'b1;
				nxt  = right_ent;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			deadline_q <= nxt.deadline;
			callback_q <= nxt.callback;
		end
	end

endmodule

### sv/timer_deadline_queue.sv
// Channel | Handshake          | Fields
// in      | in_valid/in_stall  | operation, deadline, callback_id, now
// out     | out_valid/out_stall| fired, fired_callback, fired_deadline, add_rejected, last
//
// Add: capture, then a sorted insert across the cell row.
// Check: capture, then one result word at a time as the output frees; each fired word
//   pops the head and the whole row shifts one cell toward the head.
// One word is in flight at a time; in_stall is high until it is done.
// Reset clears the cell valid bits, the state machine and out_valid.
// A stalled output word holds; the sequencer waits for the output register.
module timer_deadline_queue
	import tdq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            operation,
	input  logic [DL_W-1:0] deadline,
	input  logic [CB_W-1:0] callback_id,
	input  logic [DL_W-1:0] now,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            fired,
	output logic [CB_W-1:0] fired_callback,
	output logic [DL_W-1:0] fired_deadline,
	output logic            add_rejected,
	output logic            last
);

	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_CHECK
	} state_t;

	state_t          state_q;
	op_code_t        op_in;
	logic [DL_W-1:0] now_q;
	entry_t          new_q;
	logic [CNT_W-1:0] cnt_q;

	logic            out_valid_q;
	logic            fired_q;
	logic [CB_W-1:0] fired_callback_q;
	logic [DL_W-1:0] fired_deadline_q;
	logic            add_rejected_q;
	logic            last_q;

	// cell row: ent[QUEUE_DEPTH] is an always-empty pad past the tail
	entry_t                 ent   [0:QUEUE_DEPTH];
	entry_t                 lent  [0:QUEUE_DEPTH-1];
	logic [QUEUE_DEPTH:0]   keep_v;
	logic [QUEUE_DEPTH-1:0] valid_v;
	cell_op_t               cell_op;

	logic out_free;
	logic full;
	logic head_hit;
	logic next_hit;

	assign op_in    = op_code_t'(operation);
	assign out_free = !out_valid_q || !out_stall;
	assign full     = ent[QUEUE_DEPTH-1].valid;
	assign keep_v[0] = 1'b1;
	assign ent[QUEUE_DEPTH] = '{valid: 1'b0, deadline: '0, callback: '0};

	// head_hit: the head has expired; next_hit looks one cell down, within the
	// per-check limit, to decide whether this word closes the check
	assign head_hit = ent[0].valid && (ent[0].deadline <= now_q);
	assign next_hit = ent[1].valid && (ent[1].deadline <= now_q) && (cnt_q < CNT_LAST);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign valid_v[i] = ent[i].valid;
		if (i == 0) begin : g_first
			assign lent[i] = new_q;
		end else begin : g_rest
			assign lent[i] = ent[i-1];
		end
		tdq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (cell_op),
			.new_ent   (new_q),
			.left_ent  (lent[i]),
			.left_keep (keep_v[i]),
			.right_ent (ent[i+1]),
			.ent       (ent[i]),
			.keep      (keep_v[i+1])
		);
	end

	always_comb begin
		cell_op = CELL_HOLD;
		if (out_free) begin
			if (state_q == S_ADD && !full) begin
				cell_op = CELL_INSERT;
			end else if (state_q == S_CHECK && head_hit) begin
				cell_op = CELL_POP;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// idle drops out_valid once the word drains; busy states reload it whenever it is free
			if (state_q == S_IDLE && out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= (op_in == OP_ADD) ? S_ADD : S_CHECK;
					end
				end
				S_ADD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CHECK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 1'b1;
						if (!head_hit || !next_hit) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// captured item and output word payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			now_q <= now;
			new_q <= '{valid: 1'b1, deadline: deadline, callback: callback_id};
		end
		if (out_free && state_q == S_ADD) begin
			fired_q          <= 1'b0;
			fired_callback_q <= '0;
			fired_deadline_q <= '0;
			add_rejected_q   <= full;
			last_q           <= 1'b1;
		end else if (out_free && state_q == S_CHECK) begin
			fired_q          <= head_hit;
			fired_callback_q <= head_hit ? ent[0].callback : '0;
			fired_deadline_q <= head_hit ? ent[0].deadline : '0;
			add_rejected_q   <= 1'b0;
			last_q           <= !(head_hit && next_hit);
		end
	end

	assign out_valid      = out_valid_q;
	assign fired          = fired_q;
	assign fired_callback = fired_callback_q;
	assign fired_deadline = fired_deadline_q;
	assign add_rejected   = add_rejected_q;
	assign last           = last_q;

	// occupied cells always form a prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_v + 1'b1) & valid_v) == '0)
		else $error("cell row has a hole");

	// head is never later than its neighbor
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(ent[0].valid && ent[1].valid) |-> (ent[0].deadline <= ent[1].deadline))
		else $error("cell row out of order");

	// a fired word of the running check never reports a deadline past its time
	a_fired_due: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fired && state_q == S_CHECK && cnt_q != '0)
			|-> (fired_deadline <= now_q))
		else $error("fired entry not yet due");

	// a rejected add leaves the row full
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && add_rejected) |-> full)
		else $error("add rejected while queue had room");

endmodule
